/* hw/rtl/assert_macros.svh */
// Assertion macros used by the timekeeper core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/ftt_pkg.sv */
// Shared types and constants of the fractional tick timekeeper.
`default_nettype none

package ftt_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_CLOCK  = 2'd1,
        STATUS_NO_REALTIME = 2'd2
    } t_status;

    // Item kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Clock selections
    localparam logic [1:0] SEL_MONOTONIC = 2'd0;
    localparam logic [1:0] SEL_REALTIME  = 2'd1;

    // Configuration register indexes
    localparam logic [2:0] CFG_STEP_NS     = 3'd0;
    localparam logic [2:0] CFG_STEP_REM    = 3'd1;
    localparam logic [2:0] CFG_FREQ        = 3'd2;
    localparam logic [2:0] CFG_ORIGIN_SEC  = 3'd3;
    localparam logic [2:0] CFG_ORIGIN_NS   = 3'd4;
    localparam logic [2:0] CFG_ORIGIN_VLD  = 3'd5;

    // Configuration reset values
    localparam logic [29:0] RST_STEP_NS  = 30'd999849;
    localparam logic [23:0] RST_STEP_REM = 24'd170180;
    localparam logic [23:0] RST_FREQ     = 24'd1193180;

    // Nanoseconds per second, at the width of a sum of two 30-bit values
    localparam logic [30:0] NS_PER_SEC = 31'd1000000000;

    // Reciprocal of 1000: q = (x * US_MAGIC) >> US_SHIFT, exact for 30-bit x
    localparam logic [28:0] US_MAGIC = 29'd274877907;
    localparam int          US_SHIFT = 38;

endpackage

`default_nettype wire

/* hw/rtl/fractional_tick_timekeeper_core.sv */
// Fractional tick timekeeper: monotonic clock with realtime read-out.
//
//  channel | dir | handshake                    | payload
//  --------+-----+------------------------------+-------------------------------------
//  s_axis  | in  | s_axis_tvalid / s_axis_tready | tuser: kind, tdata: clock_select
//  m_axis  | out | m_axis_tvalid / m_axis_tready | tuser: status, tdata: sec, ns, us
//  cfg     | in  | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// One word is accepted per cycle unless a read waits on a stalled output. A tick updates
// the clock in the cycle after acceptance (step adds and two carry compares); a read
// passes the input register, time select stage and microsecond multiply into the output.
// Reset is synchronous: it clears the clock and the pipeline valids, restores the
// configuration defaults and holds both ready outputs low.
// A stalled output holds the pipeline; ticks keep draining from the input register.
`default_nettype none
`include "assert_macros.svh"

module fractional_tick_timekeeper_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input words
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [1:0] clock_select, [7:2] zero
    input  wire logic [0:0]  s_axis_tuser,   // [0] kind
    // result words
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [87:0]      m_axis_tdata,   // [31:0] seconds_out, [61:32] nanoseconds_out,
                                             // [81:62] microseconds_out, [87:82] zero
    output logic [1:0]       m_axis_tuser,   // [1:0] status
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    // Configuration registers
    logic [29:0] r_step_ns;
    logic [23:0] r_step_rem;
    logic [23:0] r_freq;
    logic [31:0] r_origin_sec;
    logic [29:0] r_origin_ns;
    logic        r_origin_vld;

    // Clock state
    logic [31:0] r_mono_sec;
    logic [29:0] r_mono_ns;
    logic [23:0] r_mono_rem;

    // Input register
    logic        r_in_valid;
    logic        r_in_kind;
    logic [1:0]  r_in_sel;

    // Time select stage
    logic             r_a_valid;
    ftt_pkg::t_status r_a_status;
    logic [31:0]      r_a_sec;
    logic [29:0]      r_a_ns;

    // Output register
    logic             r_out_valid;
    ftt_pkg::t_status r_out_status;
    logic [31:0]      r_out_sec;
    logic [29:0]      r_out_ns;
    logic [19:0]      r_out_us;

    // Flow control
    logic w_out_free;
    logic w_a_free;
    logic w_in_go;
    logic w_tick;
    logic w_read;

    // Tick arithmetic
    logic [30:0] w_ns_sum;
    logic [24:0] w_rem_sum;
    logic        w_rem_carry;
    logic [30:0] w_ns_inc;
    logic        w_sec_carry;
    logic [31:0] n_mono_sec;
    logic [29:0] n_mono_ns;
    logic [23:0] n_mono_rem;

    // Read arithmetic
    logic [30:0]      w_rt_ns_sum;
    logic             w_rt_carry;
    ftt_pkg::t_status n_a_status;
    logic [31:0]      n_a_sec;
    logic [29:0]      n_a_ns;

    // Microsecond product
    logic [58:0] w_us_prod;

    // Handshake decisions
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_a_free      = !r_a_valid || w_out_free;
    assign w_in_go       = r_in_valid && ((r_in_kind == ftt_pkg::KIND_TICK) || w_a_free);
    assign w_tick        = w_in_go && (r_in_kind == ftt_pkg::KIND_TICK);
    assign w_read        = w_in_go && (r_in_kind == ftt_pkg::KIND_READ);
    assign s_axis_tready = i_rst_n && (!r_in_valid || w_in_go);
    assign o_cfg_ready   = i_rst_n;

    // Advance the clock by one step with one remainder and one second carry
    always_comb begin
        w_ns_sum    = {1'b0, r_mono_ns} + {1'b0, r_step_ns};
        w_rem_sum   = {1'b0, r_mono_rem} + {1'b0, r_step_rem};
        w_rem_carry = (w_rem_sum >= {1'b0, r_freq});
        n_mono_rem  = w_rem_carry ? 24'(w_rem_sum - {1'b0, r_freq}) : w_rem_sum[23:0];
        w_ns_inc    = w_ns_sum + {30'd0, w_rem_carry};
        w_sec_carry = (w_ns_inc >= ftt_pkg::NS_PER_SEC);
        n_mono_ns   = w_sec_carry ? 30'(w_ns_inc - ftt_pkg::NS_PER_SEC) : w_ns_inc[29:0];
        n_mono_sec  = r_mono_sec + {31'd0, w_sec_carry};
    end

    // Select the clock for a read, add the origin for realtime, flag a bad select or no origin
    always_comb begin
        w_rt_ns_sum = {1'b0, r_mono_ns} + {1'b0, r_origin_ns};
        w_rt_carry  = (w_rt_ns_sum >= ftt_pkg::NS_PER_SEC);
        n_a_status  = ftt_pkg::STATUS_OK;
        n_a_sec     = 32'd0;
        n_a_ns      = 30'd0;
        case (r_in_sel)
            ftt_pkg::SEL_MONOTONIC: begin
                n_a_sec = r_mono_sec;
                n_a_ns  = r_mono_ns;
            end
            ftt_pkg::SEL_REALTIME: begin
                if (r_origin_vld) begin
                    n_a_sec = r_mono_sec + r_origin_sec + {31'd0, w_rt_carry};
                    n_a_ns  = w_rt_carry ? 30'(w_rt_ns_sum - ftt_pkg::NS_PER_SEC)
                                         : w_rt_ns_sum[29:0];
                end else begin
                    n_a_status = ftt_pkg::STATUS_NO_REALTIME;
                end
            end
            default: begin
                n_a_status = ftt_pkg::STATUS_BAD_CLOCK;
            end
        endcase
    end

    // Divide nanoseconds by one thousand through the reciprocal
    assign w_us_prod = 59'(r_a_ns) * 59'(ftt_pkg::US_MAGIC);

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_ns    <= ftt_pkg::RST_STEP_NS;
            r_step_rem   <= ftt_pkg::RST_STEP_REM;
            r_freq       <= ftt_pkg::RST_FREQ;
            r_origin_sec <= 32'd0;
            r_origin_ns  <= 30'd0;
            r_origin_vld <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ftt_pkg::CFG_STEP_NS:    r_step_ns    <= i_cfg_data[29:0];
                ftt_pkg::CFG_STEP_REM:   r_step_rem   <= i_cfg_data[23:0];
                ftt_pkg::CFG_FREQ:       r_freq       <= i_cfg_data[23:0];
                ftt_pkg::CFG_ORIGIN_SEC: r_origin_sec <= i_cfg_data;
                ftt_pkg::CFG_ORIGIN_NS:  r_origin_ns  <= i_cfg_data[29:0];
                ftt_pkg::CFG_ORIGIN_VLD: r_origin_vld <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Update the clock on a tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mono_sec <= 32'd0;
            r_mono_ns  <= 30'd0;
            r_mono_rem <= 24'd0;
        end else if (w_tick) begin
            r_mono_sec <= n_mono_sec;
            r_mono_ns  <= n_mono_ns;
            r_mono_rem <= n_mono_rem;
        end
    end

    // Capture input words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_in_kind <= s_axis_tuser[0];
            r_in_sel  <= s_axis_tdata[1:0];
        end
    end

    // Move reads into the time select stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_a_free) begin
            r_a_valid <= w_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_read) begin
            r_a_status <= n_a_status;
            r_a_sec    <= n_a_sec;
            r_a_ns     <= n_a_ns;
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_a_valid) begin
            r_out_status <= r_a_status;
            r_out_sec    <= r_a_sec;
            r_out_ns     <= r_a_ns;
            r_out_us     <= w_us_prod[ftt_pkg::US_SHIFT+19:ftt_pkg::US_SHIFT];
        end
    end

    // Drive the result word
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {6'd0, r_out_us, r_out_ns, r_out_sec};

    // An error result carries zero time
    `ASSERT_SAME(a_err_zero,
        r_out_valid && (r_out_status != ftt_pkg::STATUS_OK),
        (r_out_sec == 32'd0) && (r_out_ns == 30'd0) && (r_out_us == 20'd0))

    // A read never moves the clock
    `ASSERT_NEXT(a_read_keeps_clock,
        w_read,
        $stable(r_mono_sec) && $stable(r_mono_ns) && $stable(r_mono_rem))

    // A blocked select stage holds its word
    `ASSERT_NEXT(a_stage_holds,
        r_a_valid && r_out_valid && !m_axis_tready,
        r_a_valid && $stable(r_a_sec) && $stable(r_a_ns) && $stable(r_a_status))

endmodule

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the fractional tick timekeeper core.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Select codes past the realtime clock, and register indexes past the list
    localparam logic [1:0] SEL_BAD_LO  = 2'd2;
    localparam logic [1:0] SEL_BAD_HI  = 2'd3;
    localparam logic [2:0] CFG_NONE_LO = 3'd6;
    localparam logic [2:0] CFG_NONE_HI = 3'd7;

    localparam logic [63:0] NS_IN_SEC   = 64'd1000000000;
    localparam logic [63:0] NS_IN_US    = 64'd1000;
    localparam int          SETTLE_CYC  = 8;
    localparam int          PHASE_WORDS = 150;

    typedef struct {
        ftt_pkg::t_status status;
        logic [31:0]      sec;
        logic [29:0]      ns;
        logic [19:0]      us;
    } t_clock_reading;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [1:0] clock_select, [7:2] zero
    logic [0:0]  s_axis_tuser;   // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;   // [31:0] seconds, [61:32] nanoseconds, [81:62] microseconds
    logic [1:0]  m_axis_tuser;   // [1:0] status
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    fractional_tick_timekeeper_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Shadow configuration and clock state
    logic [29:0] cfg_step_ns;
    logic [23:0] cfg_step_frac;
    logic [23:0] cfg_freq;
    logic [31:0] cfg_org_sec;
    logic [29:0] cfg_org_ns;
    logic        cfg_org_vld;
    logic [31:0] clk_sec;
    logic [29:0] clk_ns;
    logic [23:0] clk_frac;

    t_clock_reading readings_due[$];
    int error_cnt      = 0;
    int rx_hold_cycles = 0;
    bit tx_idle_on     = 1'b1;
    bit rx_idle_on     = 1'b1;

    // Clock generation
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run
    initial begin
        #5000000;
        $display("tb: done, errors");
        $finish;
    end

    function automatic void reset_model();
        cfg_step_ns   = ftt_pkg::RST_STEP_NS;
        cfg_step_frac = ftt_pkg::RST_STEP_REM;
        cfg_freq      = ftt_pkg::RST_FREQ;
        cfg_org_sec   = '0;
        cfg_org_ns    = '0;
        cfg_org_vld   = 1'b0;
        clk_sec       = '0;
        clk_ns        = '0;
        clk_frac      = '0;
    endfunction

    // Take a register value at the register's width; drop unknown indexes
    function automatic void apply_config(logic [2:0] idx, logic [31:0] val);
        case (idx)
            ftt_pkg::CFG_STEP_NS:    cfg_step_ns   = val[29:0];
            ftt_pkg::CFG_STEP_REM:   cfg_step_frac = val[23:0];
            ftt_pkg::CFG_FREQ:       cfg_freq      = val[23:0];
            ftt_pkg::CFG_ORIGIN_SEC: cfg_org_sec   = val;
            ftt_pkg::CFG_ORIGIN_NS:  cfg_org_ns    = val[29:0];
            ftt_pkg::CFG_ORIGIN_VLD: cfg_org_vld   = val[0];
            default: ;
        endcase
    endfunction

    // Advance the clock by one tick: at most one nanosecond and one second carry
    function automatic void advance_clock();
        logic [63:0] ns_sum;
        logic [63:0] frac_sum;
        ns_sum   = 64'(clk_ns) + 64'(cfg_step_ns);
        frac_sum = 64'(clk_frac) + 64'(cfg_step_frac);
        if (frac_sum >= 64'(cfg_freq)) begin
            frac_sum = frac_sum - 64'(cfg_freq);
            ns_sum   = ns_sum + 64'd1;
        end
        if (ns_sum >= NS_IN_SEC) begin
            ns_sum  = ns_sum - NS_IN_SEC;
            clk_sec = clk_sec + 32'd1;
        end
        clk_ns   = ns_sum[29:0];
        clk_frac = frac_sum[23:0];
    endfunction

    // Compute what a read of the selected clock returns right now
    function automatic t_clock_reading predict_reading(logic [1:0] sel);
        t_clock_reading r;
        logic [63:0]    ns_sum;
        logic [63:0]    us_val;
        logic [31:0]    sec_sum;
        r.status = ftt_pkg::STATUS_OK;
        r.sec    = '0;
        r.ns     = '0;
        r.us     = '0;
        if (sel != ftt_pkg::SEL_MONOTONIC && sel != ftt_pkg::SEL_REALTIME) begin
            r.status = ftt_pkg::STATUS_BAD_CLOCK;
        end else if (sel == ftt_pkg::SEL_REALTIME && !cfg_org_vld) begin
            r.status = ftt_pkg::STATUS_NO_REALTIME;
        end else begin
            sec_sum = clk_sec;
            ns_sum  = 64'(clk_ns);
            if (sel == ftt_pkg::SEL_REALTIME) begin
                sec_sum = sec_sum + cfg_org_sec;
                ns_sum  = ns_sum + 64'(cfg_org_ns);
                if (ns_sum >= NS_IN_SEC) begin
                    ns_sum  = ns_sum - NS_IN_SEC;
                    sec_sum = sec_sum + 32'd1;
                end
            end
            r.sec  = sec_sum;
            r.ns   = ns_sum[29:0];
            us_val = 64'(r.ns) / NS_IN_US;
            r.us   = us_val[19:0];
        end
        return r;
    endfunction

    function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        error_cnt++;
        if (error_cnt <= 10)
            $display("tb: %s mismatch at %0t: expected %0h, got %0h", what, $realtime, want, got);
    endfunction

    // Drive the result ready: random stalls per word, plus long hold-offs on request
    initial begin : rx_ready_gen
        int gap_left;
        gap_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                m_axis_tready <= 1'b0;
            end else if (m_axis_tready === 1'b1 && m_axis_tvalid === 1'b1) begin
                gap_left = rx_idle_on ? $urandom_range(0, 8) : 0;
                m_axis_tready <= (gap_left == 0);
            end else if (gap_left > 0) begin
                gap_left--;
                m_axis_tready <= (gap_left == 0);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Compare each result word with the oldest pending reading
    initial begin : result_check
        t_clock_reading want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
                if (readings_due.size() == 0) begin
                    note_mismatch("unexpected word", '0, m_axis_tdata[31:0]);
                end else begin
                    want = readings_due.pop_front();
                    if (m_axis_tuser !== want.status)
                        note_mismatch("status", 32'(want.status), 32'(m_axis_tuser));
                    if (m_axis_tdata[31:0] !== want.sec)
                        note_mismatch("seconds", want.sec, m_axis_tdata[31:0]);
                    if (m_axis_tdata[61:32] !== want.ns)
                        note_mismatch("nanoseconds", 32'(want.ns), 32'(m_axis_tdata[61:32]));
                    if (m_axis_tdata[81:62] !== want.us)
                        note_mismatch("microseconds", 32'(want.us), 32'(m_axis_tdata[81:62]));
                end
            end
        end
    end

    // Offer one word, wait for it to be taken, then update the prediction
    task automatic send_word(input logic kind, input logic [1:0] sel);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {6'b0, sel};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        if (kind == ftt_pkg::KIND_TICK)
            advance_clock();
        else
            readings_due.push_back(predict_reading(sel));
    endtask

    // Mostly valid clock selects, with some invalid ones mixed in
    task automatic send_random_word();
        logic       kind;
        logic [1:0] sel;
        kind = ($urandom_range(0, 1) == 0) ? ftt_pkg::KIND_TICK : ftt_pkg::KIND_READ;
        if ($urandom_range(0, 9) < 8)
            sel = ($urandom_range(0, 1) == 0) ? ftt_pkg::SEL_MONOTONIC : ftt_pkg::SEL_REALTIME;
        else
            sel = ($urandom_range(0, 1) == 0) ? SEL_BAD_LO : SEL_BAD_HI;
        send_word(kind, sel);
    endtask

    // Drop the input valid, wait for every reading, then let ticks drain
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (readings_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Write one register; valid stays high for a following write
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        apply_config(idx, val);
    endtask

    task automatic cfg_close();
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_config(input logic [31:0] step_ns, input logic [31:0] step_frac,
                               input logic [31:0] freq, input logic [31:0] org_sec,
                               input logic [31:0] org_ns, input logic [31:0] org_vld);
        write_reg(ftt_pkg::CFG_STEP_NS, step_ns);
        write_reg(ftt_pkg::CFG_STEP_REM, step_frac);
        write_reg(ftt_pkg::CFG_FREQ, freq);
        write_reg(ftt_pkg::CFG_ORIGIN_SEC, org_sec);
        write_reg(ftt_pkg::CFG_ORIGIN_NS, org_ns);
        write_reg(ftt_pkg::CFG_ORIGIN_VLD, org_vld);
        cfg_close();
    endtask

    // Defaults after reset: zero clock, no origin, bad selects, tick ignores select
    task automatic test_reset_defaults();
        send_word(ftt_pkg::KIND_READ, ftt_pkg::SEL_MONOTONIC);
        send_word(ftt_pkg::KIND_READ, ftt_pkg::SEL_REALTIME);
        send_word(ftt_pkg::KIND_READ, SEL_BAD_LO);
        send_word(ftt_pkg::KIND_READ, SEL_BAD_HI);
        send_word(ftt_pkg::KIND_TICK, SEL_BAD_HI);
        send_word(ftt_pkg::KIND_TICK, ftt_pkg::SEL_MONOTONIC);
        send_word(ftt_pkg::KIND_READ, ftt_pkg::SEL_MONOTONIC);
    endtask

    // Largest legal steps and origin: carries every tick, realtime seconds wrap
    task automatic test_extreme_config();
        quiesce();
        load_config(32'd999999999, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFF_FFFF, 32'd999999999, 1);
        send_word(ftt_pkg::KIND_TICK, ftt_pkg::SEL_REALTIME);
        send_word(ftt_pkg::KIND_TICK, ftt_pkg::SEL_MONOTONIC);
        send_word(ftt_pkg::KIND_READ, ftt_pkg::SEL_MONOTONIC);
        send_word(ftt_pkg::KIND_READ, ftt_pkg::SEL_REALTIME);
        quiesce();
        load_config(32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 1);
        send_word(ftt_pkg::KIND_TICK, ftt_pkg::SEL_MONOTONIC);
        send_word(ftt_pkg::KIND_READ, ftt_pkg::SEL_REALTIME);
    endtask

    // Zero frequency: one extra nanosecond on every tick, remainder only wraps at its width
    task automatic test_zero_frequency();
        quiesce();
        load_config(32'd5, 32'h00F0_1234, 32'd0, 32'd7, 32'd999999990, 1);
        send_word(ftt_pkg::KIND_TICK, ftt_pkg::SEL_MONOTONIC);
        send_word(ftt_pkg::KIND_TICK, SEL_BAD_LO);
        send_word(ftt_pkg::KIND_TICK, ftt_pkg::SEL_MONOTONIC);
        send_word(ftt_pkg::KIND_READ, ftt_pkg::SEL_MONOTONIC);
        send_word(ftt_pkg::KIND_READ, ftt_pkg::SEL_REALTIME);
    endtask

    // All-ones writes get cut to width, unknown indexes dropped; large remainder and nanosecond sums
    task automatic test_wide_writes();
        quiesce();
        load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFF00_0003, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF);
        write_reg(CFG_NONE_LO, $urandom);
        write_reg(CFG_NONE_HI, $urandom);
        cfg_close();
        send_word(ftt_pkg::KIND_TICK, ftt_pkg::SEL_MONOTONIC);
        send_word(ftt_pkg::KIND_TICK, ftt_pkg::SEL_MONOTONIC);
        send_word(ftt_pkg::KIND_READ, ftt_pkg::SEL_MONOTONIC);
        send_word(ftt_pkg::KIND_READ, ftt_pkg::SEL_REALTIME);
    endtask

    // Hold the result side off for a long stretch while words keep coming
    task automatic test_output_backpressure();
        quiesce();
        load_config(32'd300000000, 32'd3, 32'd7, $urandom, 32'd800000000, 1);
        tx_idle_on     = 1'b0;
        rx_idle_on     = 1'b0;
        rx_hold_cycles = 300;
        repeat (60)
            send_word(($urandom_range(0, 3) != 0) ? ftt_pkg::KIND_READ : ftt_pkg::KIND_TICK,
                      ($urandom_range(0, 1) != 0) ? ftt_pkg::SEL_REALTIME
                                                  : ftt_pkg::SEL_MONOTONIC);
        quiesce();
    endtask

    // Random traffic over several register settings and idle patterns
    task automatic test_random_traffic();
        for (int p = 0; p < 8; p++) begin
            quiesce();
            case (p % 4)
                0: load_config($urandom_range(0, 999999999), $urandom_range(0, 24'hFFFFFF),
                               $urandom_range(1, 24'hFFFFFF), $urandom,
                               $urandom_range(0, 999999999), $urandom_range(0, 1));
                // fast seconds with an origin near the top of the range
                1: load_config($urandom_range(200000000, 999999999), $urandom_range(0, 15),
                               $urandom_range(1, 16), 32'hFFFF_FFFF - $urandom_range(0, 3),
                               $urandom_range(900000000, 999999999), 1);
                2: load_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                default: begin
                    if (p < 4)
                        load_config(0, 0, 1, 0, 0, 1);
                    else
                        load_config(999999999, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF,
                                    999999999, 1);
                end
            endcase
            tx_idle_on = (p % 3 != 0);
            rx_idle_on = (p % 4 != 1);
            repeat (PHASE_WORDS) send_random_word();
        end
        quiesce();
    endtask

    // Run the tests in turn
    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ftt_pkg::KIND_TICK;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= ftt_pkg::CFG_STEP_NS;
        i_cfg_data    <= '0;
        reset_model();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_extreme_config();
        test_zero_frequency();
        test_wide_writes();
        test_random_traffic();
        test_output_backpressure();

        quiesce();
        repeat (12) @(posedge i_clk);
        if (error_cnt == 0 && readings_due.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
